@@ sv/sdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdcd_pkg
// Types, codes and constants shared by the display command decoder.
// ----------------------------------------------------------------------------
package sdcd_pkg;

  localparam int FRAME_BYTES_DEF = 162;

  typedef enum logic {
    FUNC_RX  = 1'b0,
    FUNC_ACK = 1'b1
  } sdcd_func_t;

  typedef enum logic [1:0] {
    KIND_INIT     = 2'd0,
    KIND_FRAME    = 2'd1,
    KIND_CONTRAST = 2'd2
  } sdcd_kind_t;

  typedef enum logic [7:0] {
    CODE_READ     = 8'h00,
    CODE_BUTTONS  = 8'h01,
    CODE_ENCODER  = 8'h02,
    CODE_FRAME    = 8'h03,
    CODE_BUZZER   = 8'h04,
    CODE_CONTRAST = 8'h05,
    CODE_INIT     = 8'hFE
  } sdcd_code_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx_byte;
    logic        select_pressed;
    logic        pause_pressed;
    logic [15:0] encoder_count;
  } sdcd_in_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       clear_encoder;
    logic       buf_write;
    logic [7:0] buf_addr;
    logic [7:0] buf_data;
    logic       command_ready;
    logic [1:0] command_kind;
    logic       buzzer_pending;
    logic       payload_active;
  } sdcd_out_t;

  typedef struct packed {
    sdcd_kind_t latched_command;
    logic [7:0] write_position;
    logic [7:0] bytes_remaining;
    logic       ready_flag;
    logic       buzzer_flag;
  } sdcd_state_t;

endpackage

@@ sv/sdcd_decode.sv @@
// ----------------------------------------------------------------------------
// sdcd_decode
// Command/payload decode with the protocol state registers.
// ----------------------------------------------------------------------------
module sdcd_decode
  import sdcd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  sdcd_in_t  item,
  output sdcd_out_t result
);

  // payload counter is 8 bits, so a frame length saturates
  localparam int FRAME_LEN = (FRAME_BYTES > 255) ? 255 : FRAME_BYTES;

  sdcd_state_t state;
  sdcd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{latched_command: KIND_INIT, write_position: '0,
                 bytes_remaining: '0, ready_flag: 1'b0, buzzer_flag: 1'b0};
    end else if (step) begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    if (sdcd_func_t'(item.func) == FUNC_ACK) begin
      state_next.ready_flag = 1'b0;
      if (state.latched_command == KIND_FRAME) begin
        state_next.buzzer_flag = 1'b0;
      end
    end else if (state.bytes_remaining != 8'd0) begin
      result.buf_write = 1'b1;
      result.buf_addr  = state.write_position;
      result.buf_data  = item.rx_byte;
      state_next.write_position  = state.write_position + 8'd1;
      state_next.bytes_remaining = state.bytes_remaining - 8'd1;
      if (state.bytes_remaining == 8'd1) begin
        state_next.ready_flag = 1'b1;
      end
    end else begin
      case (item.rx_byte)
        CODE_BUTTONS: begin
          result.reply_valid = 1'b1;
          result.reply_byte  = {6'd0, item.pause_pressed, item.select_pressed};
        end
        CODE_ENCODER: begin
          result.reply_valid   = 1'b1;
          result.reply_byte    = item.encoder_count[7:0];
          result.clear_encoder = 1'b1;
        end
        CODE_FRAME: begin
          state_next.latched_command = KIND_FRAME;
          state_next.bytes_remaining = 8'(FRAME_LEN);
          state_next.write_position  = 8'd0;
        end
        CODE_BUZZER: begin
          state_next.buzzer_flag = 1'b1;
        end
        CODE_CONTRAST: begin
          state_next.latched_command = KIND_CONTRAST;
          state_next.bytes_remaining = 8'd1;
          state_next.write_position  = 8'd0;
        end
        CODE_INIT: begin
          state_next.latched_command = KIND_INIT;
          state_next.ready_flag      = 1'b1;
        end
        default: begin
          // read dummy and unknown codes leave everything alone
        end
      endcase
    end
    result.command_ready  = state_next.ready_flag;
    result.command_kind   = state_next.latched_command;
    result.buzzer_pending = state_next.buzzer_flag;
    result.payload_active = (state_next.bytes_remaining != 8'd0);
  end

endmodule

@@ sv/spi_display_command_decoder.sv @@
// ----------------------------------------------------------------------------
// spi_display_command_decoder
// Slave-side byte command decoder for an SPI display adapter.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req (sdcd_in_t)
//  result  | rsp_valid | rsp_stall | rsp (sdcd_out_t)
//
// One request per cycle sustained while the result is not stalled; a request
// passes the input register, then is decoded into the result register.
// Protocol state advances as a request moves into the result register.
// rst is synchronous; it empties both registers and clears the state.
// A stalled result holds; the input register still takes one more request.
module spi_display_command_decoder
  import sdcd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  sdcd_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output sdcd_out_t rsp
);

  logic      hold_valid;
  sdcd_in_t  hold;
  sdcd_out_t result;
  logic      load;
  logic      advance;

  assign load      = !rsp_valid || !rsp_stall;
  assign advance   = hold_valid && load;
  assign req_stall = hold_valid && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (!req_stall) begin
        hold_valid <= req_valid;
      end
      if (load) begin
        rsp_valid <= hold_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
    if (advance) begin
      rsp <= result;
    end
  end

  sdcd_decode #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold),
    .result (result)
  );

endmodule

@@ sv/sdcd_checker.sv @@
// ----------------------------------------------------------------------------
// sdcd_assert
// Port-level checks on the display command decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sdcd_assert
  import sdcd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input sdcd_out_t rsp
);

  // a result waiting on the far side is not withdrawn
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  // nothing leaves straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid just after reset");

  // last payload byte must raise command-ready
  a_last_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.buf_write && !rsp.payload_active |-> rsp.command_ready)
    else $error("last payload byte without command ready");

  // replies only come from command decode, never during a payload
  a_reply_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reply_valid |-> !rsp.buf_write && !rsp.payload_active)
    else $error("reply during payload");

  a_clear_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.clear_encoder |-> rsp.reply_valid)
    else $error("encoder clear without reply");

endmodule

bind spi_display_command_decoder sdcd_assert u_sdcd_assert (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

@@ tb/sv/sdcd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdcd_checker
// Watches both channels of the display command decoder. Every accepted
// request is run through a local decode of the byte protocol, and every
// accepted result is compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sdcd_checker
  import sdcd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  sdcd_in_t  req,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  sdcd_out_t rsp,
  output int        fail_count,
  output int        outstanding
);

  // payload counter is 8 bits, so long frames saturate
  localparam int FRAME_LEN = (FRAME_BYTES > 255) ? 255 : FRAME_BYTES;

  sdcd_kind_t m_kind;
  logic [7:0] m_pos;
  logic [7:0] m_left;
  logic       m_ready;
  logic       m_buzz;

  sdcd_out_t  predicted_rsp[$];
  sdcd_out_t  want;
  int         rsp_index;

  task automatic log_error(input string msg);
    $display("[%0t] result %0d: %s", $time, rsp_index, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      log_error($sformatf("%s got %0h, expected %0h", name, got, exp_val));
  endtask

  function automatic sdcd_out_t decode_request(input sdcd_in_t r);
    sdcd_out_t o;
    o = '0;
    if (r.func == FUNC_ACK) begin
      // ack retires the pending command but leaves any payload running
      m_ready = 1'b0;
      if (m_kind == KIND_FRAME) m_buzz = 1'b0;
    end else if (m_left != 8'd0) begin
      o.buf_write = 1'b1;
      o.buf_addr  = m_pos;
      o.buf_data  = r.rx_byte;
      m_pos       = m_pos + 8'd1;
      m_left      = m_left - 8'd1;
      if (m_left == 8'd0) m_ready = 1'b1;
    end else begin
      case (r.rx_byte)
        CODE_BUTTONS: begin
          o.reply_valid = 1'b1;
          o.reply_byte  = {6'd0, r.pause_pressed, r.select_pressed};
        end
        CODE_ENCODER: begin
          o.reply_valid   = 1'b1;
          o.reply_byte    = r.encoder_count[7:0];
          o.clear_encoder = 1'b1;
        end
        CODE_FRAME: begin
          m_kind = KIND_FRAME;
          m_left = 8'(FRAME_LEN);
          m_pos  = 8'd0;
        end
        CODE_BUZZER: m_buzz = 1'b1;
        CODE_CONTRAST: begin
          m_kind = KIND_CONTRAST;
          m_left = 8'd1;
          m_pos  = 8'd0;
        end
        CODE_INIT: begin
          m_kind  = KIND_INIT;
          m_ready = 1'b1;
        end
        default: ;
      endcase
    end
    o.command_ready  = m_ready;
    o.command_kind   = m_kind;
    o.buzzer_pending = m_buzz;
    o.payload_active = (m_left != 8'd0);
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_kind     = KIND_INIT;
      m_pos      = 8'd0;
      m_left     = 8'd0;
      m_ready    = 1'b0;
      m_buzz     = 1'b0;
      fail_count = 0;
      rsp_index  = 0;
      predicted_rsp.delete();
    end else begin
      // a result can never belong to a request taken on the same edge
      if (rsp_valid && !rsp_stall) begin
        if (predicted_rsp.size() == 0) begin
          log_error("result with no request outstanding");
        end else begin
          want = predicted_rsp.pop_front();
          check_field("reply_valid", 16'(rsp.reply_valid), 16'(want.reply_valid));
          check_field("reply_byte", 16'(rsp.reply_byte), 16'(want.reply_byte));
          check_field("clear_encoder", 16'(rsp.clear_encoder),
                      16'(want.clear_encoder));
          check_field("buf_write", 16'(rsp.buf_write), 16'(want.buf_write));
          check_field("buf_addr", 16'(rsp.buf_addr), 16'(want.buf_addr));
          check_field("buf_data", 16'(rsp.buf_data), 16'(want.buf_data));
          check_field("command_ready", 16'(rsp.command_ready),
                      16'(want.command_ready));
          check_field("command_kind", 16'(rsp.command_kind),
                      16'(want.command_kind));
          check_field("buzzer_pending", 16'(rsp.buzzer_pending),
                      16'(want.buzzer_pending));
          check_field("payload_active", 16'(rsp.payload_active),
                      16'(want.payload_active));
        end
        rsp_index++;
      end
      if (req_valid && !req_stall) predicted_rsp.push_back(decode_request(req));
    end
    outstanding = predicted_rsp.size();
  end

endmodule

@@ tb/sv/tb_spi_display_command_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_display_command_decoder
// Drives the display command decoder with a short directed run of commands,
// payloads and acks, then random command bursts under three idle and stall
// mixes. Checking is done by sdcd_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_spi_display_command_decoder;
  import sdcd_pkg::*;

  localparam int FRAME_BYTES = FRAME_BYTES_DEF;
  localparam int FRAME_LEN   = (FRAME_BYTES > 255) ? 255 : FRAME_BYTES;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  sdcd_in_t  req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  sdcd_out_t rsp;

  int fail_count;
  int outstanding;
  int cycle_count   = 0;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  spi_display_command_decoder #(.FRAME_BYTES(FRAME_BYTES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  sdcd_checker #(.FRAME_BYTES(FRAME_BYTES)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic sdcd_in_t make_req(input logic f, input logic [7:0] b,
                                        input logic s, input logic p,
                                        input logic [15:0] e);
    sdcd_in_t r;
    r.func           = f;
    r.rx_byte        = b;
    r.select_pressed = s;
    r.pause_pressed  = p;
    r.encoder_count  = e;
    return r;
  endfunction

  // serial byte with random button and encoder inputs
  function automatic sdcd_in_t rx_req(input logic [7:0] b);
    return make_req(FUNC_RX, b, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    16'($urandom_range(16'hFFFF)));
  endfunction

  function automatic sdcd_in_t ack_req();
    return make_req(FUNC_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
  endfunction

  // called and returns at a falling edge
  task automatic send_req(input sdcd_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic run_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_req(rx_req(CODE_FRAME));
      repeat (FRAME_LEN) begin
        if ($urandom_range(99) < 4) send_req(ack_req());
        send_req(rx_req(8'($urandom_range(255))));
      end
      if ($urandom_range(99) < 80) send_req(ack_req());
    end else if (pick < 30) begin
      send_req(rx_req(CODE_CONTRAST));
      send_req(rx_req(8'($urandom_range(255))));
      if ($urandom_range(99) < 80) send_req(ack_req());
    end else if (pick < 45) begin
      send_req(rx_req(CODE_BUTTONS));
    end else if (pick < 60) begin
      send_req(rx_req(CODE_ENCODER));
    end else if (pick < 68) begin
      send_req(rx_req(CODE_BUZZER));
    end else if (pick < 76) begin
      send_req(rx_req(CODE_INIT));
      if ($urandom_range(99) < 70) send_req(ack_req());
    end else begin
      send_req(make_req(1'($urandom_range(1)), 8'($urandom_range(255)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        16'($urandom_range(16'hFFFF))));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 14;
    stall_pct     = 79;

    // ack with nothing pending still clears ready
    send_req(ack_req());
    send_req(make_req(FUNC_RX, CODE_READ, 1'b1, 1'b1, 16'hFFFF));
    send_req(make_req(FUNC_RX, CODE_BUTTONS, 1'b1, 1'b0, 16'h0000));
    send_req(make_req(FUNC_RX, CODE_BUTTONS, 1'b0, 1'b1, 16'hFFFF));
    send_req(make_req(FUNC_RX, CODE_BUTTONS, 1'b1, 1'b1, 16'hA5A5));
    send_req(make_req(FUNC_RX, CODE_ENCODER, 1'b0, 1'b0, 16'hFFFF));
    send_req(make_req(FUNC_RX, CODE_ENCODER, 1'b1, 1'b1, 16'h0000));
    send_req(make_req(FUNC_RX, CODE_ENCODER, 1'b0, 1'b1, 16'h5A12));
    // unknown codes are dropped
    send_req(rx_req(8'hFF));
    send_req(rx_req(8'h06));
    send_req(rx_req(8'hFD));
    send_req(rx_req(CODE_INIT));
    // commands while ready: ready holds, kind is overwritten
    send_req(rx_req(CODE_BUTTONS));
    send_req(rx_req(CODE_BUZZER));
    send_req(rx_req(CODE_CONTRAST));
    send_req(rx_req(8'hFF));
    // contrast ack leaves the buzzer alone
    send_req(ack_req());
    send_req(rx_req(CODE_FRAME));
    // command codes inside a payload are data
    send_req(rx_req(CODE_ENCODER));
    send_req(rx_req(CODE_INIT));
    // frame ack clears the buzzer, payload carries on
    send_req(ack_req());
    send_req(rx_req(8'h00));

    while (items_sent < 250) run_burst();

    // hold off until every result is back
    req_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);

    send_idle_pct = 79;
    stall_pct     = 14;
    while (items_sent < 500) run_burst();

    send_idle_pct = 0;
    stall_pct     = 0;
    while (items_sent < 750) run_burst();

    req_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
